// ===== hdl/xtt_pkg.sv =====
package xtt_pkg;

    localparam int unsigned CpWidth  = 21;
    localparam int unsigned ActWidth = 2;

    typedef logic [CpWidth-1:0]  t_cp;
    typedef logic [ActWidth-1:0] t_act;

    localparam t_act ACT_START = 2'd1;
    localparam t_act ACT_END   = 2'd2;

    localparam t_cp CP_NUL    = 21'h00000;
    localparam t_cp CP_TAB    = 21'h00009;
    localparam t_cp CP_LF     = 21'h0000A;
    localparam t_cp CP_CR     = 21'h0000D;
    localparam t_cp CP_SPACE  = 21'h00020;
    localparam t_cp CP_DQUOTE = 21'h00022;
    localparam t_cp CP_AMP    = 21'h00026;
    localparam t_cp CP_APOS   = 21'h00027;
    localparam t_cp CP_SLASH  = 21'h0002F;
    localparam t_cp CP_LT     = 21'h0003C;
    localparam t_cp CP_EQ     = 21'h0003D;
    localparam t_cp CP_GT     = 21'h0003E;

    typedef enum logic [3:0] {
        PH_IDLE       = 4'd0,
        PH_START_NAME = 4'd1,
        PH_TAG_WS     = 4'd2,
        PH_ATTR_NAME  = 4'd3,
        PH_BEFORE_EQ  = 4'd4,
        PH_AFTER_EQ   = 4'd5,
        PH_VALUE      = 4'd6,
        PH_SLASH      = 4'd7,
        PH_END_NAME   = 4'd8,
        PH_END_WS     = 4'd9,
        PH_AFTER_VAL  = 4'd10
    } t_phase;

    typedef enum logic [3:0] {
        EV_NONE       = 4'd0,
        EV_START_NAME = 4'd1,
        EV_END_NAME   = 4'd2,
        EV_ATTR_NAME  = 4'd3,
        EV_VALUE_CHAR = 4'd4,
        EV_VALUE_END  = 4'd5,
        EV_GT         = 4'd6,
        EV_EMPTY_GT   = 4'd7,
        EV_END_DONE   = 4'd8,
        EV_ERROR      = 4'd9
    } t_event;

    typedef enum logic [2:0] {
        ER_NONE  = 3'd0,
        ER_NAME  = 3'd1,
        ER_EQ    = 3'd2,
        ER_QUOTE = 3'd3,
        ER_CHAR  = 3'd4,
        ER_EOF   = 3'd5,
        ER_GT    = 3'd6
    } t_err;

    function automatic logic in_range(input t_cp c, input t_cp lo, input t_cp hi);
        return (c >= lo) && (c <= hi);
    endfunction

    function automatic logic is_name_start(input t_cp c);
        return (c == 21'h0003A) || (c == 21'h0005F) ||
               in_range(c, 21'h00041, 21'h0005A) || in_range(c, 21'h00061, 21'h0007A) ||
               in_range(c, 21'h000C0, 21'h000D6) || in_range(c, 21'h000D8, 21'h000F6) ||
               in_range(c, 21'h000F8, 21'h002FF) || in_range(c, 21'h00370, 21'h0037D) ||
               in_range(c, 21'h0037F, 21'h01FFF) || in_range(c, 21'h0200C, 21'h0200D) ||
               in_range(c, 21'h02070, 21'h0218F) || in_range(c, 21'h02C00, 21'h02FEF) ||
               in_range(c, 21'h03001, 21'h0D7FF) || in_range(c, 21'h0F900, 21'h0FDCF) ||
               in_range(c, 21'h0FDF0, 21'h0FFFD) || in_range(c, 21'h10000, 21'hEFFFF);
    endfunction

    function automatic logic is_name_char(input t_cp c);
        return is_name_start(c) || (c == 21'h0002D) || (c == 21'h0002E) ||
               (c == 21'h000B7) || in_range(c, 21'h00030, 21'h00039) ||
               in_range(c, 21'h00300, 21'h0036F) || in_range(c, 21'h0203F, 21'h02040);
    endfunction

    function automatic logic is_ws(input t_cp c);
        return (c == CP_TAB) || (c == CP_LF) || (c == CP_CR) || (c == CP_SPACE);
    endfunction

endpackage

// ===== hdl/xtt_if.sv =====
interface xtt_in_if;
    logic                 valid;
    logic                 ready;
    xtt_pkg::t_cp         code_point;
    xtt_pkg::t_act        action;

    modport source (output valid, output code_point, output action, input ready);
    modport sink   (input valid, input code_point, input action, output ready);
endinterface

interface xtt_out_if;
    logic                 valid;
    logic                 ready;
    logic [3:0]           event_res;
    logic [2:0]           error_code;
    xtt_pkg::t_cp         out_code_point;

    modport source (output valid, output event_res, output error_code,
                    output out_code_point, input ready);
    modport sink   (input valid, input event_res, input error_code,
                    input out_code_point, output ready);
endinterface

// ===== hdl/xml_tag_tokenizer_unit.sv =====
// input register, then result register; tag state updates as an item leaves the first
// throughput: one code point per cycle unless backpressure stalls the result register
// the result register holds under backpressure while the input register still takes one item
// reset (synchronous, active low): phase idle, quote flag clear, both registers empty
module xml_tag_tokenizer_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    xtt_in_if.sink        i_in,
    xtt_out_if.source     o_out
);

    logic               r_in_vld;
    xtt_pkg::t_cp       r_in_cp;
    xtt_pkg::t_act      r_in_act;

    xtt_pkg::t_phase    r_phase;
    xtt_pkg::t_phase    n_phase;
    logic               r_quote_apos;
    logic               n_quote_apos;

    logic               r_out_vld;
    xtt_pkg::t_event    r_out_ev;
    xtt_pkg::t_err      r_out_err;
    xtt_pkg::t_cp       r_out_cp;

    xtt_pkg::t_event    w_ev;
    xtt_pkg::t_err      w_err;
    xtt_pkg::t_cp       w_echo;

    logic               w_adv;
    logic               w_begin;
    logic               w_ns;
    logic               w_nc;
    logic               w_ws;
    logic               w_close;

    assign w_adv   = r_in_vld && (!r_out_vld || o_out.ready);
    assign w_begin = (r_in_act == xtt_pkg::ACT_START) || (r_in_act == xtt_pkg::ACT_END);
    assign w_ns    = xtt_pkg::is_name_start(r_in_cp);
    assign w_nc    = xtt_pkg::is_name_char(r_in_cp);
    assign w_ws    = xtt_pkg::is_ws(r_in_cp);
    assign w_close = (r_in_cp == (r_quote_apos ? xtt_pkg::CP_APOS : xtt_pkg::CP_DQUOTE));

    assign i_in.ready           = !r_in_vld || w_adv;
    assign o_out.valid          = r_out_vld;
    assign o_out.event_res      = r_out_ev;
    assign o_out.error_code     = r_out_err;
    assign o_out.out_code_point = r_out_cp;

    // event and error classification
    always_comb begin
        w_ev   = xtt_pkg::EV_NONE;
        w_err  = xtt_pkg::ER_NONE;
        w_echo = xtt_pkg::CP_NUL;
        if (w_begin) begin
            if (r_in_cp == xtt_pkg::CP_NUL) begin
                w_err = xtt_pkg::ER_EOF;
            end else if (!w_ns) begin
                w_err = xtt_pkg::ER_NAME;
            end else begin
                w_ev   = (r_in_act == xtt_pkg::ACT_START) ? xtt_pkg::EV_START_NAME
                                                          : xtt_pkg::EV_END_NAME;
                w_echo = r_in_cp;
            end
        end else if (r_phase == xtt_pkg::PH_IDLE) begin
            w_ev = xtt_pkg::EV_NONE;
        end else if (r_in_cp == xtt_pkg::CP_NUL) begin
            w_err = xtt_pkg::ER_EOF;
        end else begin
            case (r_phase)
                xtt_pkg::PH_START_NAME, xtt_pkg::PH_TAG_WS, xtt_pkg::PH_AFTER_VAL: begin
                    if (r_phase == xtt_pkg::PH_START_NAME && w_nc) begin
                        w_ev   = xtt_pkg::EV_START_NAME;
                        w_echo = r_in_cp;
                    end else if (w_ws) begin
                        w_ev = xtt_pkg::EV_NONE;
                    end else if (r_phase == xtt_pkg::PH_TAG_WS && w_ns) begin
                        w_ev   = xtt_pkg::EV_ATTR_NAME;
                        w_echo = r_in_cp;
                    end else if (r_in_cp == xtt_pkg::CP_SLASH) begin
                        w_ev = xtt_pkg::EV_NONE;
                    end else if (r_in_cp == xtt_pkg::CP_GT) begin
                        w_ev = xtt_pkg::EV_GT;
                    end else begin
                        w_err = xtt_pkg::ER_GT;
                    end
                end
                xtt_pkg::PH_ATTR_NAME, xtt_pkg::PH_BEFORE_EQ: begin
                    if (r_phase == xtt_pkg::PH_ATTR_NAME && w_nc) begin
                        w_ev   = xtt_pkg::EV_ATTR_NAME;
                        w_echo = r_in_cp;
                    end else if (!w_ws && r_in_cp != xtt_pkg::CP_EQ) begin
                        w_err = xtt_pkg::ER_EQ;
                    end
                end
                xtt_pkg::PH_AFTER_EQ: begin
                    if (!w_ws && r_in_cp != xtt_pkg::CP_DQUOTE
                            && r_in_cp != xtt_pkg::CP_APOS) begin
                        w_err = xtt_pkg::ER_QUOTE;
                    end
                end
                xtt_pkg::PH_VALUE: begin
                    if (w_close) begin
                        w_ev = xtt_pkg::EV_VALUE_END;
                    end else if (r_in_cp == xtt_pkg::CP_AMP || r_in_cp == xtt_pkg::CP_LT) begin
                        w_err = xtt_pkg::ER_CHAR;
                    end else begin
                        w_ev   = xtt_pkg::EV_VALUE_CHAR;
                        w_echo = r_in_cp;
                    end
                end
                xtt_pkg::PH_SLASH: begin
                    if (r_in_cp == xtt_pkg::CP_GT) begin
                        w_ev = xtt_pkg::EV_EMPTY_GT;
                    end else begin
                        w_err = xtt_pkg::ER_GT;
                    end
                end
                xtt_pkg::PH_END_NAME, xtt_pkg::PH_END_WS: begin
                    if (r_phase == xtt_pkg::PH_END_NAME && w_nc) begin
                        w_ev   = xtt_pkg::EV_END_NAME;
                        w_echo = r_in_cp;
                    end else if (w_ws) begin
                        w_ev = xtt_pkg::EV_NONE;
                    end else if (r_in_cp == xtt_pkg::CP_GT) begin
                        w_ev = xtt_pkg::EV_END_DONE;
                    end else begin
                        w_err = xtt_pkg::ER_GT;
                    end
                end
                default: begin
                    w_ev = xtt_pkg::EV_NONE;
                end
            endcase
        end
        if (w_err != xtt_pkg::ER_NONE) begin
            w_ev   = xtt_pkg::EV_ERROR;
            w_echo = xtt_pkg::CP_NUL;
        end
    end

    // next phase
    always_comb begin
        n_phase      = r_phase;
        n_quote_apos = r_quote_apos;
        if (w_begin) begin
            n_phase = (r_in_act == xtt_pkg::ACT_START) ? xtt_pkg::PH_START_NAME
                                                       : xtt_pkg::PH_END_NAME;
        end else begin
            case (r_phase)
                xtt_pkg::PH_START_NAME, xtt_pkg::PH_TAG_WS, xtt_pkg::PH_AFTER_VAL: begin
                    if (r_phase == xtt_pkg::PH_START_NAME && w_nc) begin
                        n_phase = r_phase;
                    end else if (w_ws) begin
                        n_phase = xtt_pkg::PH_TAG_WS;
                    end else if (r_phase == xtt_pkg::PH_TAG_WS && w_ns) begin
                        n_phase = xtt_pkg::PH_ATTR_NAME;
                    end else if (r_in_cp == xtt_pkg::CP_SLASH) begin
                        n_phase = xtt_pkg::PH_SLASH;
                    end else if (r_in_cp == xtt_pkg::CP_GT) begin
                        n_phase = xtt_pkg::PH_IDLE;
                    end
                end
                xtt_pkg::PH_ATTR_NAME, xtt_pkg::PH_BEFORE_EQ: begin
                    if (r_phase == xtt_pkg::PH_ATTR_NAME && w_nc) begin
                        n_phase = r_phase;
                    end else if (w_ws) begin
                        n_phase = xtt_pkg::PH_BEFORE_EQ;
                    end else if (r_in_cp == xtt_pkg::CP_EQ) begin
                        n_phase = xtt_pkg::PH_AFTER_EQ;
                    end
                end
                xtt_pkg::PH_AFTER_EQ: begin
                    if (r_in_cp == xtt_pkg::CP_DQUOTE || r_in_cp == xtt_pkg::CP_APOS) begin
                        n_phase      = xtt_pkg::PH_VALUE;
                        n_quote_apos = (r_in_cp == xtt_pkg::CP_APOS);
                    end
                end
                xtt_pkg::PH_VALUE: begin
                    if (w_close) begin
                        n_phase = xtt_pkg::PH_AFTER_VAL;
                    end
                end
                xtt_pkg::PH_SLASH: begin
                    if (r_in_cp == xtt_pkg::CP_GT) begin
                        n_phase = xtt_pkg::PH_IDLE;
                    end
                end
                xtt_pkg::PH_END_NAME, xtt_pkg::PH_END_WS: begin
                    if (r_phase == xtt_pkg::PH_END_NAME && w_nc) begin
                        n_phase = r_phase;
                    end else if (w_ws) begin
                        n_phase = xtt_pkg::PH_END_WS;
                    end else if (r_in_cp == xtt_pkg::CP_GT) begin
                        n_phase = xtt_pkg::PH_IDLE;
                    end
                end
                default: begin
                    n_phase = xtt_pkg::PH_IDLE;
                end
            endcase
        end
        if (w_err != xtt_pkg::ER_NONE) begin
            n_phase = xtt_pkg::PH_IDLE;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_cp  <= i_in.code_point;
            r_in_act <= i_in.action;
        end
    end

    // tag state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= xtt_pkg::PH_IDLE;
            r_quote_apos <= 1'b0;
        end else if (w_adv) begin
            r_phase      <= n_phase;
            r_quote_apos <= n_quote_apos;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_ev  <= w_ev;
            r_out_err <= w_err;
            r_out_cp  <= w_echo;
        end
    end

    a_err_code_matches_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ((r_out_ev == xtt_pkg::EV_ERROR) == (r_out_err != xtt_pkg::ER_NONE)))
        else $error("error code disagrees with event");

    a_echo_only_for_chars: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_ev != xtt_pkg::EV_START_NAME && r_out_ev != xtt_pkg::EV_END_NAME
            && r_out_ev != xtt_pkg::EV_ATTR_NAME && r_out_ev != xtt_pkg::EV_VALUE_CHAR)
        |-> (r_out_cp == xtt_pkg::CP_NUL))
        else $error("code point echoed for a non-character event");

    a_idle_after_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_err != xtt_pkg::ER_NONE) |=> (r_phase == xtt_pkg::PH_IDLE))
        else $error("phase not idle after error");

    a_state_holds_without_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> ($stable(r_phase) && $stable(r_quote_apos)))
        else $error("tag state moved without an item");

    a_pending_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_adv) |=> (r_in_vld && $stable(r_in_cp) && $stable(r_in_act)))
        else $error("stalled input item lost");

endmodule

// ===== dv/xml_tag_tokenizer_unit_tb.sv =====
module xml_tag_tokenizer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam xtt_pkg::t_act ACT_CONT = 2'd0;
    localparam xtt_pkg::t_act ACT_ODD  = 2'd3;

    localparam int NumStartRanges = 16;
    localparam int NumNameRanges  = 22;
    localparam int RandomItems    = 1150;
    localparam int StallLimit     = 4000;
    localparam int DrainCycles    = 10;

    typedef struct packed {
        xtt_pkg::t_event ev;
        xtt_pkg::t_err   err;
        xtt_pkg::t_cp    cp;
    } t_token;

    logic clk;
    logic rst_n;

    xtt_in_if  in_if();
    xtt_out_if out_if();

    xml_tag_tokenizer_unit dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_token          tokens_due[$];
    xtt_pkg::t_phase tag_phase;
    bit              apos_open;
    bit              steady;
    int              items_sent;
    int              results_seen;
    int              mismatch_count;
    int              seq_pos;
    int              break_at;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // character classes of the tag grammar
    function automatic bit between(input xtt_pkg::t_cp c, input xtt_pkg::t_cp lo,
                                   input xtt_pkg::t_cp hi);
        return (c >= lo) && (c <= hi);
    endfunction

    function automatic bit starts_name(input xtt_pkg::t_cp c);
        if (c == 21'h3A || c == 21'h5F)
            return 1'b1;
        if (between(c, 21'h41, 21'h5A) || between(c, 21'h61, 21'h7A))
            return 1'b1;
        if (between(c, 21'hC0, 21'h2FF))
            return !(c == 21'hD7 || c == 21'hF7);
        if (between(c, 21'h370, 21'h1FFF))
            return c != 21'h37E;
        return between(c, 21'h200C, 21'h200D) || between(c, 21'h2070, 21'h218F) ||
               between(c, 21'h2C00, 21'h2FEF) || between(c, 21'h3001, 21'hD7FF) ||
               between(c, 21'hF900, 21'hFDCF) || between(c, 21'hFDF0, 21'hFFFD) ||
               between(c, 21'h10000, 21'hEFFFF);
    endfunction

    function automatic bit continues_name(input xtt_pkg::t_cp c);
        return starts_name(c) || between(c, 21'h2D, 21'h2E) || between(c, 21'h30, 21'h39) ||
               c == 21'hB7 || between(c, 21'h300, 21'h36F) || between(c, 21'h203F, 21'h2040);
    endfunction

    function automatic bit is_blank(input xtt_pkg::t_cp c);
        return c == xtt_pkg::CP_TAB || c == xtt_pkg::CP_LF || c == xtt_pkg::CP_CR ||
               c == xtt_pkg::CP_SPACE;
    endfunction

    task automatic predict_token(input xtt_pkg::t_cp c, input xtt_pkg::t_act act,
                                 output bit live);
        t_token          tok;
        xtt_pkg::t_phase nxt;
        tok  = '{xtt_pkg::EV_NONE, xtt_pkg::ER_NONE, xtt_pkg::CP_NUL};
        nxt  = tag_phase;
        live = 1'b1;
        if (act == xtt_pkg::ACT_START || act == xtt_pkg::ACT_END) begin
            if (c == xtt_pkg::CP_NUL) begin
                tok.err = xtt_pkg::ER_EOF;
            end else if (!starts_name(c)) begin
                tok.err = xtt_pkg::ER_NAME;
            end else begin
                tok.ev = (act == xtt_pkg::ACT_START) ? xtt_pkg::EV_START_NAME
                                                     : xtt_pkg::EV_END_NAME;
                tok.cp = c;
                nxt    = (act == xtt_pkg::ACT_START) ? xtt_pkg::PH_START_NAME
                                                     : xtt_pkg::PH_END_NAME;
            end
        end else if (tag_phase == xtt_pkg::PH_IDLE) begin
            live = 1'b0;
        end else if (c == xtt_pkg::CP_NUL) begin
            tok.err = xtt_pkg::ER_EOF;
        end else begin
            case (tag_phase)
                xtt_pkg::PH_START_NAME, xtt_pkg::PH_TAG_WS, xtt_pkg::PH_AFTER_VAL: begin
                    if (tag_phase == xtt_pkg::PH_START_NAME && continues_name(c)) begin
                        tok.ev = xtt_pkg::EV_START_NAME;
                        tok.cp = c;
                    end else if (is_blank(c)) begin
                        nxt = xtt_pkg::PH_TAG_WS;
                    end else if (tag_phase == xtt_pkg::PH_TAG_WS && starts_name(c)) begin
                        tok.ev = xtt_pkg::EV_ATTR_NAME;
                        tok.cp = c;
                        nxt    = xtt_pkg::PH_ATTR_NAME;
                    end else if (c == xtt_pkg::CP_SLASH) begin
                        nxt = xtt_pkg::PH_SLASH;
                    end else if (c == xtt_pkg::CP_GT) begin
                        tok.ev = xtt_pkg::EV_GT;
                        nxt    = xtt_pkg::PH_IDLE;
                    end else begin
                        tok.err = xtt_pkg::ER_GT;
                    end
                end
                xtt_pkg::PH_ATTR_NAME, xtt_pkg::PH_BEFORE_EQ: begin
                    if (tag_phase == xtt_pkg::PH_ATTR_NAME && continues_name(c)) begin
                        tok.ev = xtt_pkg::EV_ATTR_NAME;
                        tok.cp = c;
                    end else if (is_blank(c)) begin
                        nxt = xtt_pkg::PH_BEFORE_EQ;
                    end else if (c == xtt_pkg::CP_EQ) begin
                        nxt = xtt_pkg::PH_AFTER_EQ;
                    end else begin
                        tok.err = xtt_pkg::ER_EQ;
                    end
                end
                xtt_pkg::PH_AFTER_EQ: begin
                    if (c == xtt_pkg::CP_DQUOTE || c == xtt_pkg::CP_APOS) begin
                        apos_open = (c == xtt_pkg::CP_APOS);
                        nxt       = xtt_pkg::PH_VALUE;
                    end else if (!is_blank(c)) begin
                        tok.err = xtt_pkg::ER_QUOTE;
                    end
                end
                xtt_pkg::PH_VALUE: begin
                    if (c == (apos_open ? xtt_pkg::CP_APOS : xtt_pkg::CP_DQUOTE)) begin
                        tok.ev = xtt_pkg::EV_VALUE_END;
                        nxt    = xtt_pkg::PH_AFTER_VAL;
                    end else if (c == xtt_pkg::CP_AMP || c == xtt_pkg::CP_LT) begin
                        tok.err = xtt_pkg::ER_CHAR;
                    end else begin
                        tok.ev = xtt_pkg::EV_VALUE_CHAR;
                        tok.cp = c;
                    end
                end
                xtt_pkg::PH_SLASH: begin
                    if (c == xtt_pkg::CP_GT) begin
                        tok.ev = xtt_pkg::EV_EMPTY_GT;
                        nxt    = xtt_pkg::PH_IDLE;
                    end else begin
                        tok.err = xtt_pkg::ER_GT;
                    end
                end
                default: begin
                    if (tag_phase == xtt_pkg::PH_END_NAME && continues_name(c)) begin
                        tok.ev = xtt_pkg::EV_END_NAME;
                        tok.cp = c;
                    end else if (is_blank(c)) begin
                        nxt = xtt_pkg::PH_END_WS;
                    end else if (c == xtt_pkg::CP_GT) begin
                        tok.ev = xtt_pkg::EV_END_DONE;
                        nxt    = xtt_pkg::PH_IDLE;
                    end else begin
                        tok.err = xtt_pkg::ER_GT;
                    end
                end
            endcase
        end
        if (tok.err != xtt_pkg::ER_NONE) begin
            tok.ev = xtt_pkg::EV_ERROR;
            tok.cp = xtt_pkg::CP_NUL;
            nxt    = xtt_pkg::PH_IDLE;
        end
        tag_phase = nxt;
        tokens_due.push_back(tok);
    endtask

    // stimulus value pickers
    function automatic logic [41:0] name_range(input int k);
        case (k)
            0:       return {21'h0003A, 21'h0003A};
            1:       return {21'h0005F, 21'h0005F};
            2:       return {21'h00041, 21'h0005A};
            3:       return {21'h00061, 21'h0007A};
            4:       return {21'h000C0, 21'h000D6};
            5:       return {21'h000D8, 21'h000F6};
            6:       return {21'h000F8, 21'h002FF};
            7:       return {21'h00370, 21'h0037D};
            8:       return {21'h0037F, 21'h01FFF};
            9:       return {21'h0200C, 21'h0200D};
            10:      return {21'h02070, 21'h0218F};
            11:      return {21'h02C00, 21'h02FEF};
            12:      return {21'h03001, 21'h0D7FF};
            13:      return {21'h0F900, 21'h0FDCF};
            14:      return {21'h0FDF0, 21'h0FFFD};
            15:      return {21'h10000, 21'hEFFFF};
            16:      return {21'h0002D, 21'h0002E};
            17:      return {21'h000B7, 21'h000B7};
            18:      return {21'h00030, 21'h00039};
            19:      return {21'h00300, 21'h0036F};
            20:      return {21'h0203F, 21'h02040};
            default: return {21'h0002D, 21'h0002D};
        endcase
    endfunction

    function automatic xtt_pkg::t_cp pick_in(input int k);
        logic [41:0] b;
        b = name_range(k);
        case ($urandom_range(9))
            0:       return b[41:21];
            1:       return b[20:0];
            default: return xtt_pkg::t_cp'($urandom_range(b[20:0], b[41:21]));
        endcase
    endfunction

    function automatic xtt_pkg::t_cp name_start_cp();
        return pick_in($urandom_range(NumStartRanges - 1));
    endfunction

    function automatic xtt_pkg::t_cp name_cp();
        if ($urandom_range(3) == 0)
            return pick_in(NumStartRanges + $urandom_range(NumNameRanges - NumStartRanges - 1));
        return name_start_cp();
    endfunction

    function automatic xtt_pkg::t_cp boundary_cp();
        logic [41:0] b;
        int          base;
        b    = name_range($urandom_range(NumNameRanges - 1));
        base = $urandom_range(1) ? int'(b[41:21]) : int'(b[20:0]);
        return xtt_pkg::t_cp'(base + int'($urandom_range(2)) - 1);
    endfunction

    function automatic xtt_pkg::t_cp any_cp();
        case ($urandom_range(9))
            0, 1, 2, 3: return xtt_pkg::t_cp'($urandom_range(21'h7F));
            4, 5, 6:    return xtt_pkg::t_cp'($urandom_range(21'hFFFF));
            default:    return xtt_pkg::t_cp'($urandom_range(21'h10FFFF));
        endcase
    endfunction

    function automatic xtt_pkg::t_cp blank_cp();
        case ($urandom_range(3))
            0:       return xtt_pkg::CP_TAB;
            1:       return xtt_pkg::CP_LF;
            2:       return xtt_pkg::CP_CR;
            default: return xtt_pkg::CP_SPACE;
        endcase
    endfunction

    function automatic xtt_pkg::t_cp syntax_cp();
        case ($urandom_range(7))
            0:       return xtt_pkg::CP_DQUOTE;
            1:       return xtt_pkg::CP_APOS;
            2:       return xtt_pkg::CP_EQ;
            3:       return xtt_pkg::CP_SLASH;
            4:       return xtt_pkg::CP_GT;
            5:       return xtt_pkg::CP_AMP;
            6:       return xtt_pkg::CP_LT;
            default: return xtt_pkg::CP_NUL;
        endcase
    endfunction

    function automatic xtt_pkg::t_cp value_cp(input xtt_pkg::t_cp q);
        xtt_pkg::t_cp c;
        if ($urandom_range(4) == 0)
            return (q == xtt_pkg::CP_APOS) ? xtt_pkg::CP_DQUOTE : xtt_pkg::CP_APOS;
        do
            c = any_cp();
        while (c == xtt_pkg::CP_NUL || c == q || c == xtt_pkg::CP_AMP || c == xtt_pkg::CP_LT);
        return c;
    endfunction

    function automatic xtt_pkg::t_act cont_act();
        return ($urandom_range(9) == 0) ? ACT_ODD : ACT_CONT;
    endfunction

    task automatic send_char(input xtt_pkg::t_cp c, input xtt_pkg::t_act act);
        bit live;
        @(negedge clk);
        while (!steady && $urandom_range(99) < 24) begin
            in_if.valid      <= 1'b0;
            in_if.code_point <= any_cp();
            in_if.action     <= xtt_pkg::t_act'($urandom_range(3));
            @(negedge clk);
        end
        in_if.valid      <= 1'b1;
        in_if.code_point <= c;
        in_if.action     <= act;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        predict_token(c, act, live);
        if (live)
            items_sent++;
    endtask

    task automatic begin_seq();
        seq_pos  = 0;
        break_at = ($urandom_range(99) < 15) ? int'($urandom_range(15)) : -1;
    endtask

    // sends one character of a sequence, corrupting it at the break point
    task automatic put(input xtt_pkg::t_cp c, input xtt_pkg::t_act act);
        if (seq_pos == break_at) begin
            case ($urandom_range(3))
                0:       c = syntax_cp();
                1:       c = any_cp();
                2:       c = boundary_cp();
                default: c = blank_cp();
            endcase
            act = ($urandom_range(4) == 0) ? xtt_pkg::ACT_START : cont_act();
        end
        seq_pos++;
        send_char(c, act);
    endtask

    task automatic put_ws(input int n);
        repeat (n) put(blank_cp(), cont_act());
    endtask

    task automatic random_start_tag();
        xtt_pkg::t_cp q;
        begin_seq();
        put(name_start_cp(), xtt_pkg::ACT_START);
        repeat ($urandom_range(3)) put(name_cp(), cont_act());
        repeat ($urandom_range(3)) begin
            put_ws(1 + $urandom_range(1));
            put(name_start_cp(), cont_act());
            repeat ($urandom_range(2)) put(name_cp(), cont_act());
            put_ws($urandom_range(1));
            put(xtt_pkg::CP_EQ, cont_act());
            put_ws($urandom_range(1));
            q = $urandom_range(1) ? xtt_pkg::CP_APOS : xtt_pkg::CP_DQUOTE;
            put(q, cont_act());
            repeat ($urandom_range(4)) put(value_cp(q), cont_act());
            put(q, cont_act());
        end
        put_ws($urandom_range(1));
        if ($urandom_range(1))
            put(xtt_pkg::CP_SLASH, cont_act());
        put(xtt_pkg::CP_GT, cont_act());
    endtask

    task automatic random_end_tag();
        begin_seq();
        put(name_start_cp(), xtt_pkg::ACT_END);
        repeat ($urandom_range(3)) put(name_cp(), cont_act());
        put_ws($urandom_range(2));
        put(xtt_pkg::CP_GT, cont_act());
    endtask

    task automatic random_noise();
        xtt_pkg::t_cp c;
        repeat (1 + $urandom_range(3)) begin
            case ($urandom_range(3))
                0:       c = any_cp();
                1:       c = boundary_cp();
                2:       c = blank_cp();
                default: c = syntax_cp();
            endcase
            send_char(c, xtt_pkg::t_act'($urandom_range(3)));
        end
    endtask

    task automatic report_mismatch(input string what, input logic [20:0] got,
                                   input logic [20:0] want);
        mismatch_count++;
        $display("%0t: result %0d %s got %h want %h", $realtime, results_seen, what,
                 got, want);
    endtask

    always @(posedge clk) begin
        t_token tok;
        if (rst_n && out_if.valid && out_if.ready) begin
            results_seen++;
            if (tokens_due.size() == 0) begin
                report_mismatch("unexpected transfer", 21'(out_if.event_res), 21'd0);
            end else begin
                tok = tokens_due.pop_front();
                if (out_if.event_res !== tok.ev)
                    report_mismatch("event", 21'(out_if.event_res), 21'(tok.ev));
                if (out_if.error_code !== tok.err)
                    report_mismatch("error code", 21'(out_if.error_code), 21'(tok.err));
                if (out_if.out_code_point !== tok.cp)
                    report_mismatch("code point", out_if.out_code_point, tok.cp);
            end
        end
    end

    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            out_if.ready <= steady || ($urandom_range(99) >= 24);
        end
    end

    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                stall = 0;
            else
                stall++;
            if (stall >= StallLimit) begin
                $display("xml_tag_tokenizer_unit_tb: done, errors");
                $finish;
            end
        end
    end

    task automatic test_idle_input();
        send_char(21'h10FFFF, ACT_CONT);
        send_char(xtt_pkg::CP_NUL, ACT_ODD);
    endtask

    task automatic test_tag_openers();
        send_char(xtt_pkg::CP_NUL, xtt_pkg::ACT_START);
        send_char(21'h0002D, xtt_pkg::ACT_END);
    endtask

    // attribute with the other quote inside, then a character right after the value
    task automatic test_attribute_tag();
        send_char(21'h0005F, xtt_pkg::ACT_START);
        send_char(21'h10000, ACT_ODD);
        send_char(xtt_pkg::CP_TAB, ACT_CONT);
        send_char(21'h0003A, ACT_CONT);
        send_char(xtt_pkg::CP_LF, ACT_CONT);
        send_char(xtt_pkg::CP_EQ, ACT_CONT);
        send_char(xtt_pkg::CP_SPACE, ACT_CONT);
        send_char(xtt_pkg::CP_APOS, ACT_CONT);
        send_char(xtt_pkg::CP_DQUOTE, ACT_CONT);
        send_char(xtt_pkg::CP_APOS, ACT_CONT);
        send_char(21'h0007A, ACT_CONT);
    endtask

    task automatic test_end_tag();
        send_char(21'h00062, xtt_pkg::ACT_END);
        send_char(21'h0203F, ACT_CONT);
        send_char(xtt_pkg::CP_CR, ACT_CONT);
        send_char(xtt_pkg::CP_GT, ACT_CONT);
    endtask

    task automatic test_restart();
        send_char(21'h0006B, xtt_pkg::ACT_START);
        send_char(xtt_pkg::CP_SPACE, ACT_CONT);
        send_char(21'h0006D, xtt_pkg::ACT_START);
        send_char(xtt_pkg::CP_SLASH, ACT_CONT);
        send_char(xtt_pkg::CP_GT, ACT_CONT);
    endtask

    task automatic test_tag_close();
        send_char(21'h00063, xtt_pkg::ACT_START);
        send_char(xtt_pkg::CP_NUL, ACT_CONT);
        send_char(21'hEFFFF, xtt_pkg::ACT_START);
        send_char(xtt_pkg::CP_GT, ACT_CONT);
    endtask

    task automatic test_random_tags();
        int stop_at;
        int pick;
        stop_at = items_sent + RandomItems;
        while (items_sent < stop_at) begin
            steady = (items_sent >= stop_at - 700) && (items_sent < stop_at - 500);
            pick   = $urandom_range(99);
            if (pick < 15)
                random_noise();
            else if (pick < 35)
                random_end_tag();
            else
                random_start_tag();
        end
        steady = 1'b0;
    endtask

    initial begin
        rst_n            = 1'b0;
        in_if.valid      = 1'b0;
        in_if.code_point = xtt_pkg::CP_NUL;
        in_if.action     = ACT_CONT;
        tag_phase        = xtt_pkg::PH_IDLE;
        apos_open        = 1'b0;
        steady           = 1'b0;
        items_sent       = 0;
        results_seen     = 0;
        mismatch_count   = 0;
        seq_pos          = 0;
        break_at         = -1;
        repeat (8) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        test_idle_input();
        test_tag_openers();
        test_attribute_tag();
        test_end_tag();
        test_restart();
        test_tag_close();
        test_random_tags();

        @(negedge clk) in_if.valid <= 1'b0;
        while (tokens_due.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (mismatch_count == 0)
            $display("xml_tag_tokenizer_unit_tb: done, clean");
        else
            $display("xml_tag_tokenizer_unit_tb: done, errors");
        $finish;
    end

endmodule
